### hw/rtl/idoi_pkg.sv
package idoi_pkg;

  localparam int MAX_ENTRIES_DEF = 256;
  localparam int QUEUE_DEPTH     = 2;

  localparam logic [15:0] KIND_TERRAIN_PART = 16'd2;
  localparam logic [15:0] KIND_COVER        = 16'd4;

  typedef enum logic [1:0] {
    CMD_CLEAR  = 2'd0,
    CMD_INSERT = 2'd1,
    CMD_READ   = 2'd2,
    CMD_NOP    = 2'd3
  } cmd_e_t;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_RANGE = 2'd2
  } status_t;

  typedef struct packed {
    logic [1:0]  command;
    logic [11:0] tile_x;
    logic [11:0] tile_y;
    logic [15:0] object_kind;
    logic [7:0]  base_width;
    logic [7:0]  base_height;
    logic [9:0]  object_handle;
    logic [7:0]  read_index;
  } in_t;

  typedef struct packed {
    logic [7:0]  position;
    logic [9:0]  entry_handle;
    logic [11:0] entry_x;
    logic [11:0] entry_y;
    logic [8:0]  entry_count;
    logic [1:0]  status;
  } out_t;

  // classified operation passed from front to back
  typedef struct packed {
    cmd_e_t      cmd;
    logic [11:0] x;
    logic [11:0] y;
    logic [7:0]  w;
    logic [7:0]  h;
    logic [9:0]  handle;
    logic [7:0]  index;
  } op_t;

  typedef struct packed {
    logic [11:0] x;
    logic [11:0] y;
    logic [7:0]  w;
    logic [7:0]  h;
    logic [9:0]  handle;
  } entry_t;

  localparam int ENTRY_W = $bits(entry_t);

  typedef enum logic [3:0] {
    B_IDLE,
    B_START,
    B_READ_WAIT,
    B_WALK_RD,
    B_WALK_EV,
    B_PULL_RD,
    B_PULL_EV,
    B_FWD_RD,
    B_FWD_EV,
    B_POST,
    B_FIRST_RD,
    B_FIRST_EV,
    B_SH_INIT,
    B_SH_RD,
    B_SH_WR,
    B_WRITE
  } bstate_t;

endpackage

### hw/rtl/idoi_ram.sv
module idoi_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

### hw/rtl/idoi_queue.sv
module idoi_queue (
  input  logic            clk,
  input  logic            rst,
  input  logic            push,
  input  idoi_pkg::op_t   push_data,
  output logic            full,
  input  logic            pop,
  output idoi_pkg::op_t   head,
  output logic            empty
);

  localparam int PW = (idoi_pkg::QUEUE_DEPTH > 1) ? $clog2(idoi_pkg::QUEUE_DEPTH) : 1;
  localparam int CW = $clog2(idoi_pkg::QUEUE_DEPTH + 1);

  idoi_pkg::op_t   slots [idoi_pkg::QUEUE_DEPTH];
  logic [PW-1:0]   wptr;
  logic [PW-1:0]   rptr;
  logic [CW-1:0]   fill;

  assign full  = (fill == CW'(idoi_pkg::QUEUE_DEPTH));
  assign empty = (fill == '0);
  assign head  = slots[rptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr <= '0;
      rptr <= '0;
      fill <= '0;
    end else begin
      if (push && !full) begin
        wptr <= (wptr == PW'(idoi_pkg::QUEUE_DEPTH - 1)) ? '0 : wptr + 1'b1;
      end
      if (pop && !empty) begin
        rptr <= (rptr == PW'(idoi_pkg::QUEUE_DEPTH - 1)) ? '0 : rptr + 1'b1;
      end
      if ((push && !full) && !(pop && !empty)) begin
        fill <= fill + 1'b1;
      end else if (!(push && !full) && (pop && !empty)) begin
        fill <= fill - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push && !full) begin
      slots[wptr] <= push_data;
    end
  end

endmodule

### hw/rtl/idoi_front.sv
module idoi_front (
  input  logic           clk,
  input  logic           rst,
  input  logic           in_valid,
  output logic           in_ready,
  input  idoi_pkg::in_t  in_data,
  output logic           push,
  output idoi_pkg::op_t  push_data,
  input  logic           q_full
);

  logic          hold_vld;
  idoi_pkg::op_t hold;
  idoi_pkg::op_t op_next;
  logic          sized;

  // terrain parts and cover use their base footprint, zero raised to one
  assign sized = (in_data.object_kind == idoi_pkg::KIND_TERRAIN_PART) ||
                 (in_data.object_kind == idoi_pkg::KIND_COVER);

  always_comb begin
    op_next.cmd    = idoi_pkg::cmd_e_t'(in_data.command);
    op_next.x      = in_data.tile_x;
    op_next.y      = in_data.tile_y;
    op_next.w      = 8'd1;
    op_next.h      = 8'd1;
    op_next.handle = in_data.object_handle;
    op_next.index  = in_data.read_index;
    if (sized) begin
      op_next.w = (in_data.base_width  == 8'd0) ? 8'd1 : in_data.base_width;
      op_next.h = (in_data.base_height == 8'd0) ? 8'd1 : in_data.base_height;
    end
  end

  assign push      = hold_vld && !q_full;
  assign push_data = hold;
  assign in_ready  = !hold_vld || !q_full;

  always_ff @(posedge clk) begin
    if (rst) begin
      hold_vld <= 1'b0;
    end else if (in_valid && in_ready) begin
      hold_vld <= 1'b1;
    end else if (push) begin
      hold_vld <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      hold <= op_next;
    end
  end

endmodule

### hw/rtl/idoi_back.sv
module idoi_back #(
  parameter int MAX_ENTRIES = idoi_pkg::MAX_ENTRIES_DEF
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           q_empty,
  input  idoi_pkg::op_t  q_head,
  output logic           q_pop,
  output logic           out_valid,
  input  logic           out_ready,
  output idoi_pkg::out_t out_data
);

  localparam int AW = $clog2(MAX_ENTRIES);
  localparam int CW = $clog2(MAX_ENTRIES + 1);

  idoi_pkg::bstate_t state, state_next;

  logic [CW-1:0]  total, total_next;
  idoi_pkg::op_t  op, op_next;
  logic [12:0]    nsum, nsum_next;
  logic [12:0]    osum, osum_next;
  logic [CW-1:0]  ci, ci_next;
  logic [CW-1:0]  p, p_next;
  logic [CW-1:0]  pos, pos_next;
  logic [CW-1:0]  k, k_next;
  logic [AW-1:0]  after, after_next;
  logic           after_vld, after_vld_next;
  idoi_pkg::out_t res, res_next;
  logic           res_vld, res_vld_next;
  logic           out_valid_next;
  idoi_pkg::out_t out_data_next;

  logic                         we;
  logic [AW-1:0]                waddr;
  logic [idoi_pkg::ENTRY_W-1:0] wdata;
  logic [AW-1:0]                raddr;
  logic [idoi_pkg::ENTRY_W-1:0] rdata;

  idoi_pkg::entry_t e;
  idoi_pkg::entry_t n;
  logic [12:0] esum;
  logic        no_x, no_y, counts, behind;
  logic        pull_ok, fwd_ok, first_hit, pull_stop, idx_ok, full, out_free;

  idoi_ram #(.WIDTH(idoi_pkg::ENTRY_W), .DEPTH(MAX_ENTRIES)) u_store (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .raddr (raddr),
    .rdata (rdata)
  );

  assign e    = idoi_pkg::entry_t'(rdata);
  assign n    = '{x: op.x, y: op.y, w: op.w, h: op.h, handle: op.handle};
  assign esum = {1'b0, e.x} + {1'b0, e.y};

  // footprint extends from the anchor toward lower coordinates
  assign no_x = (({2'b0, op.x} + 14'd1) > ({2'b0, e.x} + {6'b0, op.w})) ||
                (({2'b0, e.x} + 14'd1) > ({2'b0, op.x} + {6'b0, e.w}));
  assign no_y = (({2'b0, op.y} + 14'd1) > ({2'b0, e.y} + {6'b0, op.h})) ||
                (({2'b0, e.y} + 14'd1) > ({2'b0, op.y} + {6'b0, e.h}));
  assign counts = !no_x || !no_y;
  assign behind = no_x ? (op.x < e.x) : (op.y < e.y);

  assign pull_ok   = (osum == esum) || (nsum < esum);
  assign fwd_ok    = (osum == esum) || (nsum > esum);
  assign first_hit = (nsum < esum);
  assign pull_stop = (pos == '0) ||
                     (after_vld && (pos <= (CW'(after) + CW'(1))));
  assign idx_ok    = ({{CW{1'b0}}, op.index} < {8'b0, total});
  assign full      = (total == CW'(MAX_ENTRIES));
  assign out_free  = !out_valid || out_ready;
  assign q_pop     = (state == idoi_pkg::B_IDLE) && !q_empty && !res_vld;

  always_comb begin
    state_next = state;
    unique case (state)
      idoi_pkg::B_IDLE:      if (q_pop) state_next = idoi_pkg::B_START;
      idoi_pkg::B_START: begin
        unique case (op.cmd)
          idoi_pkg::CMD_READ:
            state_next = idx_ok ? idoi_pkg::B_READ_WAIT : idoi_pkg::B_IDLE;
          idoi_pkg::CMD_INSERT:
            state_next = full ? idoi_pkg::B_IDLE : idoi_pkg::B_WALK_RD;
          idoi_pkg::CMD_CLEAR,
          idoi_pkg::CMD_NOP:   state_next = idoi_pkg::B_IDLE;
        endcase
      end
      idoi_pkg::B_READ_WAIT: state_next = idoi_pkg::B_IDLE;
      idoi_pkg::B_WALK_RD:
        state_next = (ci == total) ? idoi_pkg::B_POST : idoi_pkg::B_WALK_EV;
      idoi_pkg::B_WALK_EV: begin
        if (!counts) begin
          state_next = idoi_pkg::B_WALK_RD;
        end else if (behind) begin
          state_next = idoi_pkg::B_PULL_RD;
        end else begin
          state_next = idoi_pkg::B_FWD_RD;
        end
      end
      idoi_pkg::B_PULL_RD:
        state_next = pull_stop ? idoi_pkg::B_SH_INIT : idoi_pkg::B_PULL_EV;
      idoi_pkg::B_PULL_EV:
        state_next = pull_ok ? idoi_pkg::B_PULL_RD : idoi_pkg::B_SH_INIT;
      idoi_pkg::B_FWD_RD:
        state_next = (p == total) ? idoi_pkg::B_WALK_RD : idoi_pkg::B_FWD_EV;
      idoi_pkg::B_FWD_EV:
        state_next = fwd_ok ? idoi_pkg::B_FWD_RD : idoi_pkg::B_WALK_RD;
      idoi_pkg::B_POST:
        state_next = after_vld ? idoi_pkg::B_SH_INIT : idoi_pkg::B_FIRST_RD;
      idoi_pkg::B_FIRST_RD:
        state_next = (ci == total) ? idoi_pkg::B_SH_INIT : idoi_pkg::B_FIRST_EV;
      idoi_pkg::B_FIRST_EV:
        state_next = first_hit ? idoi_pkg::B_SH_INIT : idoi_pkg::B_FIRST_RD;
      idoi_pkg::B_SH_INIT:   state_next = idoi_pkg::B_SH_RD;
      idoi_pkg::B_SH_RD:
        state_next = (k == pos) ? idoi_pkg::B_WRITE : idoi_pkg::B_SH_WR;
      idoi_pkg::B_SH_WR:     state_next = idoi_pkg::B_SH_RD;
      idoi_pkg::B_WRITE:     state_next = idoi_pkg::B_IDLE;
      default:               state_next = idoi_pkg::B_IDLE;
    endcase
  end

  always_comb begin
    total_next     = total;
    op_next        = op;
    nsum_next      = nsum;
    osum_next      = osum;
    ci_next        = ci;
    p_next         = p;
    pos_next       = pos;
    k_next         = k;
    after_next     = after;
    after_vld_next = after_vld;
    res_next       = res;
    res_vld_next   = res_vld;
    out_valid_next = out_valid && !out_ready;
    out_data_next  = out_data;
    we             = 1'b0;
    waddr          = k[AW-1:0];
    wdata          = rdata;
    raddr          = '0;

    // finished result moves to the output register once it is free
    if (res_vld && out_free) begin
      out_valid_next             = 1'b1;
      out_data_next              = res;
      out_data_next.entry_count  = 9'(total);
      res_vld_next               = 1'b0;
    end

    unique case (state)
      idoi_pkg::B_IDLE: begin
        if (q_pop) begin
          op_next = q_head;
        end
      end
      idoi_pkg::B_START: begin
        res_next       = '0;
        nsum_next      = {1'b0, op.x} + {1'b0, op.y};
        ci_next        = '0;
        after_vld_next = 1'b0;
        unique case (op.cmd)
          idoi_pkg::CMD_CLEAR: begin
            total_next   = '0;
            res_vld_next = 1'b1;
          end
          idoi_pkg::CMD_READ: begin
            raddr             = AW'(op.index);
            res_next.position = op.index;
            if (!idx_ok) begin
              res_next.status = idoi_pkg::ST_RANGE;
              res_vld_next    = 1'b1;
            end
          end
          idoi_pkg::CMD_INSERT: begin
            if (full) begin
              res_next.entry_handle = op.handle;
              res_next.entry_x      = op.x;
              res_next.entry_y      = op.y;
              res_next.status       = idoi_pkg::ST_FULL;
              res_vld_next          = 1'b1;
            end
          end
          idoi_pkg::CMD_NOP: begin
            res_vld_next = 1'b1;
          end
        endcase
      end
      idoi_pkg::B_READ_WAIT: begin
        res_next.entry_handle = e.handle;
        res_next.entry_x      = e.x;
        res_next.entry_y      = e.y;
        res_vld_next          = 1'b1;
      end
      idoi_pkg::B_WALK_RD: begin
        raddr = ci[AW-1:0];
      end
      idoi_pkg::B_WALK_EV: begin
        if (!counts) begin
          ci_next = ci + 1'b1;
        end else if (behind) begin
          pos_next  = ci;
          osum_next = esum;
        end else begin
          after_next     = ci[AW-1:0];
          after_vld_next = 1'b1;
          osum_next      = esum;
          p_next         = ci + 1'b1;
        end
      end
      idoi_pkg::B_PULL_RD: begin
        raddr = AW'(pos - 1'b1);
      end
      idoi_pkg::B_PULL_EV: begin
        if (pull_ok) begin
          pos_next = pos - 1'b1;
        end
      end
      idoi_pkg::B_FWD_RD: begin
        raddr = p[AW-1:0];
        if (p == total) begin
          ci_next = ci + 1'b1;
        end
      end
      idoi_pkg::B_FWD_EV: begin
        if (fwd_ok) begin
          after_next = p[AW-1:0];
          p_next     = p + 1'b1;
        end else begin
          ci_next = ci + 1'b1;
        end
      end
      idoi_pkg::B_POST: begin
        pos_next = CW'(after) + CW'(1);
        ci_next  = '0;
      end
      idoi_pkg::B_FIRST_RD: begin
        raddr = ci[AW-1:0];
        if (ci == total) begin
          pos_next = total;
        end
      end
      idoi_pkg::B_FIRST_EV: begin
        if (first_hit) begin
          pos_next = ci;
        end else begin
          ci_next = ci + 1'b1;
        end
      end
      idoi_pkg::B_SH_INIT: begin
        k_next = total;
      end
      idoi_pkg::B_SH_RD: begin
        raddr = AW'(k - 1'b1);
      end
      idoi_pkg::B_SH_WR: begin
        we     = 1'b1;
        waddr  = k[AW-1:0];
        wdata  = rdata;
        k_next = k - 1'b1;
      end
      idoi_pkg::B_WRITE: begin
        we                    = 1'b1;
        waddr                 = pos[AW-1:0];
        wdata                 = n;
        total_next            = total + 1'b1;
        res_next.position     = 8'(pos);
        res_next.entry_handle = op.handle;
        res_next.entry_x      = op.x;
        res_next.entry_y      = op.y;
        res_next.status       = idoi_pkg::ST_OK;
        res_vld_next          = 1'b1;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= idoi_pkg::B_IDLE;
      total     <= '0;
      res_vld   <= 1'b0;
      out_valid <= 1'b0;
      after_vld <= 1'b0;
    end else begin
      state     <= state_next;
      total     <= total_next;
      res_vld   <= res_vld_next;
      out_valid <= out_valid_next;
      after_vld <= after_vld_next;
    end
  end

  always_ff @(posedge clk) begin
    op       <= op_next;
    nsum     <= nsum_next;
    osum     <= osum_next;
    ci       <= ci_next;
    p        <= p_next;
    pos      <= pos_next;
    k        <= k_next;
    after    <= after_next;
    res      <= res_next;
    out_data <= out_data_next;
  end

endmodule

### hw/rtl/isometric_depth_order_insert.sv
// Insert: the placement walk reads each entry it visits, rescanning each forward run, then
// every entry from the insertion point upward is shifted up one slot; all of this is bound
// by the single read port of the entry memory.
// The back end works on one transaction at a time; the front queue takes up to three
// more. Reset empties the list and the queue; the memory is not cleared.
module isometric_depth_order_insert #(
  parameter int MAX_ENTRIES = idoi_pkg::MAX_ENTRIES_DEF
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           in_valid,
  output logic           in_ready,
  input  idoi_pkg::in_t  in_data,
  output logic           out_valid,
  input  logic           out_ready,
  output idoi_pkg::out_t out_data
);

  logic          push;
  idoi_pkg::op_t push_data;
  logic          q_full;
  logic          q_pop;
  idoi_pkg::op_t q_head;
  logic          q_empty;

  idoi_front u_front (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .push      (push),
    .push_data (push_data),
    .q_full    (q_full)
  );

  idoi_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (push_data),
    .full      (q_full),
    .pop       (q_pop),
    .head      (q_head),
    .empty     (q_empty)
  );

  idoi_back #(.MAX_ENTRIES(MAX_ENTRIES)) u_back (
    .clk       (clk),
    .rst       (rst),
    .q_empty   (q_empty),
    .q_head    (q_head),
    .q_pop     (q_pop),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule

### tb/sv/tb_isometric_depth_order_insert.sv
`timescale 1ns / 1ps

module tb_isometric_depth_order_insert;

  localparam int LIST_DEPTH  = 256;
  localparam int CYCLE_LIMIT = 30_000_000;
  localparam int IN_W        = $bits(idoi_pkg::in_t);

  class depth_list_scoreboard;
    int     slot_x[LIST_DEPTH];
    int     slot_y[LIST_DEPTH];
    int     slot_w[LIST_DEPTH];
    int     slot_h[LIST_DEPTH];
    int     slot_tag[LIST_DEPTH];
    int     count;
    idoi_pkg::out_t pending[$];
    int     errors;

    function int diag(int i);
      return slot_x[i] + slot_y[i];
    endfunction

    // insertion point by footprint overlap, then by diagonal sum
    function int place(int nx, int ny, int nw, int nh);
      int  nsum;
      int  after;
      int  osum;
      int  pos;
      bit  nox;
      bit  noy;
      bit  behind;
      nsum  = nx + ny;
      after = -1;
      for (int ci = 0; ci < count; ci++) begin
        nox = (nx - nw + 1 - slot_x[ci] > 0) || (slot_x[ci] - slot_w[ci] + 1 - nx > 0);
        if (nox) begin
          noy = (ny - nh + 1 - slot_y[ci] > 0) || (slot_y[ci] - slot_h[ci] + 1 - ny > 0);
          if (noy) continue;
          behind = nx < slot_x[ci];
        end else begin
          behind = ny < slot_y[ci];
        end
        osum = diag(ci);
        if (behind) begin
          pos = ci;
          for (int p = ci - 1; p >= 0; p--) begin
            if ((osum == diag(p) || nsum < diag(p)) && p > after) pos = p;
            else break;
          end
          return pos;
        end
        after = ci;
        for (int p = ci + 1; p < count; p++) begin
          if (osum == diag(p) || nsum > diag(p)) after = p;
          else break;
        end
      end
      if (after != -1) return after + 1;
      for (int ci = 0; ci < count; ci++)
        if (nsum < diag(ci)) return ci;
      return count;
    endfunction

    function void note_input(idoi_pkg::in_t d);
      idoi_pkg::out_t r;
      int   nw;
      int   nh;
      int   pos;
      int   idx;
      r = '0;
      idx = int'(d.read_index);
      case (idoi_pkg::cmd_e_t'(d.command))
        idoi_pkg::CMD_CLEAR: count = 0;
        idoi_pkg::CMD_INSERT: begin
          nw = 1;
          nh = 1;
          if (d.object_kind == idoi_pkg::KIND_TERRAIN_PART ||
              d.object_kind == idoi_pkg::KIND_COVER) begin
            nw = (d.base_width == 8'd0) ? 1 : int'(d.base_width);
            nh = (d.base_height == 8'd0) ? 1 : int'(d.base_height);
          end
          r.entry_handle = d.object_handle;
          r.entry_x      = d.tile_x;
          r.entry_y      = d.tile_y;
          if (count >= LIST_DEPTH) begin
            r.status = idoi_pkg::ST_FULL;
          end else begin
            pos = place(int'(d.tile_x), int'(d.tile_y), nw, nh);
            if (pos > count) pos = count;
            for (int i = count; i > pos; i--) begin
              slot_x[i]   = slot_x[i-1];
              slot_y[i]   = slot_y[i-1];
              slot_w[i]   = slot_w[i-1];
              slot_h[i]   = slot_h[i-1];
              slot_tag[i] = slot_tag[i-1];
            end
            slot_x[pos]   = int'(d.tile_x);
            slot_y[pos]   = int'(d.tile_y);
            slot_w[pos]   = nw;
            slot_h[pos]   = nh;
            slot_tag[pos] = int'(d.object_handle);
            count++;
            r.position = 8'(pos);
          end
        end
        idoi_pkg::CMD_READ: begin
          r.position = d.read_index;
          if (idx < count) begin
            r.entry_handle = 10'(slot_tag[idx]);
            r.entry_x      = 12'(slot_x[idx]);
            r.entry_y      = 12'(slot_y[idx]);
          end else begin
            r.status = idoi_pkg::ST_RANGE;
          end
        end
        default: ;
      endcase
      r.entry_count = 9'(count);
      pending = {pending, r};
    endfunction

    function void cmp(string field, int exp_v, int act_v);
      if (exp_v != act_v) begin
        $error("%s: expected %0d, got %0d", field, exp_v, act_v);
        errors++;
      end
    endfunction

    function void check_result(idoi_pkg::out_t a);
      idoi_pkg::out_t e;
      if (pending.size() == 0) begin
        $error("unexpected result transaction %h", a);
        errors++;
        return;
      end
      e = pending.pop_front();
      cmp("position", int'(e.position), int'(a.position));
      cmp("entry_handle", int'(e.entry_handle), int'(a.entry_handle));
      cmp("entry_x", int'(e.entry_x), int'(a.entry_x));
      cmp("entry_y", int'(e.entry_y), int'(a.entry_y));
      cmp("entry_count", int'(e.entry_count), int'(a.entry_count));
      cmp("status", int'(e.status), int'(a.status));
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_ready;
  idoi_pkg::in_t  in_data = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  idoi_pkg::out_t out_data;

  int send_idle = 0;
  int rcv_stall = 0;
  bit hold_req = 1'b0;
  int hold_left = 0;
  int cycles = 0;
  int sent = 0;

  depth_list_scoreboard sb = new();

  isometric_depth_order_insert dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data)
  );

  initial begin
    forever #1 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("[isometric_depth_order_insert] ERROR");
      $finish;
    end
  end

  // receiver: random stalls plus one long hold-off counted here
  always @(posedge clk) begin
    if (hold_req) begin
      hold_left <= 3000;
      out_ready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(99) >= rcv_stall);
    end
  end

  // handshake sampled mid-cycle; the transaction completes at the next rising edge
  always @(negedge clk) begin
    if (!rst && out_valid && out_ready) sb.check_result(out_data);
  end

  task automatic send(idoi_pkg::in_t d);
    while ($urandom_range(99) < send_idle) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= d;
    do @(negedge clk); while (!in_ready);
    sb.note_input(d);
    sent++;
    @(posedge clk);
  endtask

  function automatic idoi_pkg::in_t make_op(idoi_pkg::cmd_e_t c);
    idoi_pkg::in_t d;
    d = IN_W'({$urandom, $urandom, $urandom});
    d.command = c;
    return d;
  endfunction

  function automatic idoi_pkg::in_t make_insert(int x, int y, logic [15:0] kind, int w, int h,
                                                int tag);
    idoi_pkg::in_t d;
    d = make_op(idoi_pkg::CMD_INSERT);
    d.tile_x        = 12'(x);
    d.tile_y        = 12'(y);
    d.object_kind   = kind;
    d.base_width    = 8'(w);
    d.base_height   = 8'(h);
    d.object_handle = 10'(tag);
    return d;
  endfunction

  function automatic idoi_pkg::in_t make_read(int idx);
    idoi_pkg::in_t d;
    d = make_op(idoi_pkg::CMD_READ);
    d.read_index = 8'(idx);
    return d;
  endfunction

  function automatic idoi_pkg::in_t rand_insert(int span);
    idoi_pkg::in_t d;
    int  roll;
    d = make_op(idoi_pkg::CMD_INSERT);
    d.tile_x = (span < 4095) ? 12'($urandom_range(span)) : 12'($urandom_range(4095));
    d.tile_y = (span < 4095) ? 12'($urandom_range(span)) : 12'($urandom_range(4095));
    roll = int'($urandom_range(99));
    if (roll < 40) d.object_kind = idoi_pkg::KIND_TERRAIN_PART;
    else if (roll < 70) d.object_kind = idoi_pkg::KIND_COVER;
    if ($urandom_range(9) != 0) begin
      d.base_width  = 8'($urandom_range(5));
      d.base_height = 8'($urandom_range(5));
    end
    return d;
  endfunction

  initial begin
    int   span;
    int   run;
    int   roll;
    idoi_pkg::in_t  d;
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed
    send(make_op(idoi_pkg::CMD_CLEAR));
    send(make_read(0));
    send(make_op(idoi_pkg::CMD_NOP));
    send(make_insert(5, 5, idoi_pkg::KIND_TERRAIN_PART, 0, 0, 1));
    send(make_insert(4095, 4095, idoi_pkg::KIND_COVER, 255, 255, 2));
    send(make_insert(0, 0, 16'd0, 9, 9, 3));
    send(make_insert(0, 4095, 16'hFFFF, 255, 255, 1023));
    send(make_insert(5, 3, idoi_pkg::KIND_TERRAIN_PART, 2, 2, 4));   // X overlap, behind
    send(make_insert(5, 7, 16'd0, 0, 0, 5));                         // X overlap, in front
    send(make_insert(6, 5, 16'd0, 0, 0, 6));                         // Y overlap only
    send(make_insert(3, 5, idoi_pkg::KIND_COVER, 3, 1, 7));
    send(make_insert(4094, 4093, idoi_pkg::KIND_COVER, 4, 4, 8));
    for (int i = 0; i < 4; i++) send(make_read(i));
    send(make_read(9));
    send(make_read(255));
    send(make_op(idoi_pkg::CMD_NOP));
    send(make_op(idoi_pkg::CMD_CLEAR));
    // fill to capacity with disjoint ascending entries, then overflow
    for (int i = 0; i < LIST_DEPTH; i++)
      send(make_insert(i * 3, i * 5, 16'd0, 0, 0, i));
    send(make_insert(7, 7, idoi_pkg::KIND_COVER, 3, 3, 999));
    send(make_read(255));
    send(make_read(0));
    send(make_op(idoi_pkg::CMD_CLEAR));
    in_valid <= 1'b0;

    // long receiver hold-off while the sender keeps offering
    @(negedge clk) hold_req = 1'b1;
    @(negedge clk) hold_req = 1'b0;
    @(posedge clk);
    for (int i = 0; i < 12; i++) send((i % 2) ? make_read(i) : rand_insert(8));

    while (sent < 1170) begin
      case ((sent / 200) % 4)
        0: begin send_idle = 0;  rcv_stall = 0;  end
        1: begin send_idle = 55; rcv_stall = 0;  end
        2: begin send_idle = 0;  rcv_stall = 55; end
        default: begin send_idle = 34; rcv_stall = 34; end
      endcase
      roll = int'($urandom_range(9));
      span = (roll < 5) ? 8 : (roll < 8) ? 32 : 4095;
      run  = ($urandom_range(9) == 0) ? 40 : int'($urandom_range(1, 24));
      send(make_op(idoi_pkg::CMD_CLEAR));
      for (int k = 0; k < run; k++) begin
        roll = int'($urandom_range(99));
        if (roll < 75) d = rand_insert(span);
        else if (roll < 90) d = make_read(int'($urandom_range(sb.count + 1)));
        else if (roll < 95) d = make_op(idoi_pkg::CMD_NOP);
        else d = IN_W'({$urandom, $urandom, $urandom});
        send(d);
      end
    end
    in_valid <= 1'b0;

    while (sb.pending.size() != 0) @(posedge clk);
    repeat (50) @(posedge clk);
    if (sb.errors == 0) begin
      $display("[isometric_depth_order_insert] OK");
    end else begin
      $display("[isometric_depth_order_insert] ERROR");
    end
    $finish;
  end

endmodule
